@@ src/ccis_pkg.sv @@
package ccis_pkg;

  // Fraction bits of the internal angle and log datapath
  localparam int IQ = 24;
  localparam int PI_Q = 52707179;
  localparam int HALF_PI_Q = 26353589;
  localparam logic [23:0] LN2_Q = 24'd11629080;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_PART  = 2'd1;
  localparam logic [1:0] REQ_END   = 2'd2;

  localparam logic [1:0] CFG_CONE_RADIUS = 2'd0;
  localparam logic [1:0] CFG_ETA_LIMIT   = 2'd1;

  localparam logic [7:0] STATUS_FINAL = 8'd1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQZ,
    ST_PTCHK,
    ST_SQRT_PT,
    ST_SQRT_P,
    ST_DIV,
    ST_NORM,
    ST_LN,
    ST_ETA,
    ST_ROT,
    ST_CORDIC,
    ST_PHI,
    ST_CUT,
    ST_SQE,
    ST_SQP,
    ST_SQR,
    ST_DEC
  } state_e;

  // atan(2^-i) in Q24
  function automatic logic [23:0] atan_step(input logic [5:0] i);
    logic [23:0] r;
    case (i)
      6'd0: r = 24'd13176795;
      6'd1: r = 24'd7778716;
      6'd2: r = 24'd4110060;
      6'd3: r = 24'd2086331;
      6'd4: r = 24'd1047214;
      6'd5: r = 24'd524117;
      6'd6: r = 24'd262123;
      6'd7: r = 24'd131069;
      default: r = (i < 6'd24) ? (24'd1 << (6'd24 - i)) : 24'd0;
    endcase
    return r;
  endfunction

  // ln(1 + 2^-i) in Q24 for i >= 1 (entry 0 is zero)
  function automatic logic [23:0] ln1p_step(input logic [5:0] i);
    logic [23:0] r;
    case (i)
      6'd0: r = 24'd0;
      6'd1: r = 24'd6802576;
      6'd2: r = 24'd3743728;
      6'd3: r = 24'd1976071;
      6'd4: r = 24'd1017112;
      6'd5: r = 24'd516263;
      6'd6: r = 24'd260117;
      6'd7: r = 24'd130563;
      6'd8: r = 24'd65536 - 24'd128;
      6'd9: r = 24'd32768 - 24'd32;
      6'd10: r = 24'd16384 - 24'd8;
      6'd11: r = 24'd8192 - 24'd2;
      default: r = (i <= 6'd24) ? (24'd1 << (6'd24 - i)) : 24'd0;
    endcase
    return r;
  endfunction

endpackage

@@ src/ccis_mul.sv @@
module ccis_mul (
  input  logic        clk_i,
  input  logic [23:0] a_i,
  input  logic [23:0] b_i,
  output logic [47:0] prod_o
);

  logic [47:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= 48'(a_i) * 48'(b_i);
  end

  assign prod_o = prod_q;

endmodule

@@ src/charged_cone_isolation_sum.sv @@
// Charged-particle cone isolation sum.
// Requests come in on in_valid_i/in_stall_o: a start request carries the
// reference momentum and clears the sum, a particle request may add its pt,
// an end request puts the sum on out_valid_o/cone_sum_o. Request type 3
// is dropped.
// Start and accepted particle requests run through one shared 24x24
// multiplier, a shared compare/subtract unit (two square roots of 31
// steps, a 56-step restoring divide), a log normalize loop (k octaves
// of (p+|pz|)/pt, 0 to 24), CORDIC_STEPS shift-and-add log steps and
// CORDIC_STEPS circular CORDIC steps. A start or particle keeps the block
// busy throughout; one outside the eta cut skips the cone test, a zero-pt
// request ends at the pt check, and status/charge rejects and drops leave
// the block idle. An end request shows up on out_valid_o in the cycle
// after it is taken. The input side stalls while busy and while a result
// is held with out_stall_i high.
// Reset clears the reference to (0,0), the sum to zero and the registers
// to cone_radius 410 and eta_limit 2560. Config writes on cfg_we_i are
// meant to be issued only while the block is idle.
module charged_cone_isolation_sum #(
  parameter int ANGLE_FRAC_BITS = 10,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [13:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [23:0] mom_x_i,
  input  logic signed [23:0] mom_y_i,
  input  logic signed [23:0] mom_z_i,
  input  logic [7:0]         status_i,
  input  logic signed [2:0]  charge_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        cone_sum_o
);

  localparam int A = ANGLE_FRAC_BITS;
  localparam int S = CORDIC_STEPS;
  localparam int SHR = ccis_pkg::IQ - A;
  localparam int ETA_W = A + 7;
  localparam int REF_ETA_W = A + 6;
  localparam int PHI_W = A + 3;
  localparam int DPHI_W = A + 5;
  localparam int DETA_W = A + 8;
  localparam int D2_W = 2 * A + 15;
  localparam int CUT_W = A + 17;
  localparam int CMP_W = 2 * A + 36;
  localparam int RND_HALF = 1 << (SHR - 1);
  localparam int PI_A = (ccis_pkg::PI_Q + RND_HALF) >> SHR;
  localparam logic [63:0] D2_MIN = (64'd1 << (2 * A)) / 64'd10000;
  localparam logic signed [REF_ETA_W-1:0] ETA_SAT = REF_ETA_W'((1 << (A + 5)) - 1);
  localparam logic signed [ETA_W-1:0] ETA_SAT_W = ETA_W'((1 << (A + 5)) - 1);
  localparam logic signed [DPHI_W-1:0] PI_S = DPHI_W'(PI_A);
  localparam logic signed [DPHI_W-1:0] TWO_PI_S = DPHI_W'(2 * PI_A);

  ccis_pkg::state_e state_q, state_d;

  logic [13:0] cone_radius_q, cone_radius_d, eta_limit_q, eta_limit_d;
  logic signed [REF_ETA_W-1:0] ref_eta_q, ref_eta_d;
  logic signed [PHI_W-1:0] ref_phi_q, ref_phi_d;
  logic [31:0] sum_q, sum_d, cone_sum_q, cone_sum_d;
  logic out_valid_q, out_valid_d;

  logic signed [23:0] px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic start_q, start_d;
  logic [47:0] ptsq_q, ptsq_d;
  logic [61:0] work_q, work_d;
  logic [34:0] rem_q, rem_d;
  logic [30:0] root_q, root_d, pt7_q, pt7_d;
  logic [24:0] pt_q, pt_d;
  logic [5:0] cnt_q, cnt_d;
  logic [29:0] acc_q, acc_d;
  logic [25:0] t_q, t_d;
  logic signed [ETA_W-1:0] eta_q, eta_d;
  logic signed [35:0] x_q, x_d, y_q, y_d;
  logic signed [27:0] z_q, z_d;
  logic signed [PHI_W-1:0] phi_q, phi_d;
  logic [DETA_W-1:0] dabs_e_q, dabs_e_d;
  logic [DPHI_W-1:0] dabs_p_q, dabs_p_d;
  logic [D2_W-1:0] d2_q, d2_d;

  logic in_acc, out_acc;
  logic [23:0] ax, ay, az, mul_a, mul_b;
  logic [47:0] prod;
  logic [34:0] sub_a, sub_b, diff;
  logic ge;
  logic [30:0] root_nx;
  logic [31:0] num;
  logic [25:0] ln_c;
  logic [30:0] mag_full;
  logic signed [ETA_W-1:0] mag;
  logic signed [35:0] x0, y0, xs, ys;
  logic signed [27:0] atn;
  logic signed [28:0] zr;
  logic [ETA_W-1:0] aeta;
  logic signed [DETA_W-1:0] deta;
  logic signed [DPHI_W-1:0] dphi;
  logic [CUT_W-1:0] cut_l, cut_r;
  logic [CMP_W-1:0] cmp_l, cmp_r;
  logic [32:0] sum_ext;

  assign in_acc = in_valid_i & ~in_stall_o;
  assign out_acc = out_valid_q & ~out_stall_i;
  assign in_stall_o = (state_q != ccis_pkg::ST_IDLE) | (out_valid_q & out_stall_i);
  assign out_valid_o = out_valid_q;
  assign cone_sum_o = cone_sum_q;

  assign ax = px_q[23] ? 24'(-px_q) : 24'(px_q);
  assign ay = py_q[23] ? 24'(-py_q) : 24'(py_q);
  assign az = pz_q[23] ? 24'(-pz_q) : 24'(pz_q);

  ccis_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // shared compare/subtract for square root and divide
  always_comb begin
    if (state_q == ccis_pkg::ST_DIV) begin
      sub_a = {rem_q[33:0], work_q[55]};
      sub_b = 35'(pt7_q);
    end else begin
      sub_a = {rem_q[32:0], work_q[61:60]};
      sub_b = {2'b00, root_q, 2'b01};
    end
    ge = sub_a >= sub_b;
    diff = sub_a - sub_b;
  end

  assign root_nx = {root_q[29:0], ge};
  assign num = 32'(root_nx) + {1'b0, az, 7'd0};
  assign ln_c = t_q + (t_q >> cnt_q);
  assign mag_full = ({1'b0, acc_q} + 31'(RND_HALF)) >> SHR;
  assign mag = $signed(mag_full[ETA_W-1:0]);
  assign x0 = {{4{px_q[23]}}, px_q, 8'd0};
  assign y0 = {{4{py_q[23]}}, py_q, 8'd0};
  assign xs = x_q >>> cnt_q;
  assign ys = y_q >>> cnt_q;
  assign atn = $signed(28'(ccis_pkg::atan_step(cnt_q)));
  assign zr = 29'(z_q) + 29'(RND_HALF);
  assign aeta = eta_q[ETA_W-1] ? ETA_W'(-eta_q) : ETA_W'(eta_q);
  assign deta = DETA_W'(eta_q) - DETA_W'(ref_eta_q);
  assign cut_l = CUT_W'(aeta) << 10;
  assign cut_r = CUT_W'(eta_limit_q) << A;
  assign cmp_l = CMP_W'(d2_q) << 20;
  assign cmp_r = CMP_W'(prod[27:0]) << (2 * A);
  assign sum_ext = {1'b0, sum_q} + 33'(pt_q);

  always_comb begin
    dphi = DPHI_W'(phi_q) - DPHI_W'(ref_phi_q);
    if (dphi > PI_S) begin
      dphi = dphi - TWO_PI_S;
    end else if (dphi < -PI_S) begin
      dphi = dphi + TWO_PI_S;
    end
  end

  always_comb begin
    state_d = state_q;
    cone_radius_d = cone_radius_q;
    eta_limit_d = eta_limit_q;
    ref_eta_d = ref_eta_q;
    ref_phi_d = ref_phi_q;
    sum_d = sum_q;
    cone_sum_d = cone_sum_q;
    out_valid_d = out_valid_q & ~out_acc;
    px_d = px_q;
    py_d = py_q;
    pz_d = pz_q;
    start_d = start_q;
    ptsq_d = ptsq_q;
    work_d = work_q;
    rem_d = rem_q;
    root_d = root_q;
    pt7_d = pt7_q;
    pt_d = pt_q;
    cnt_d = cnt_q;
    acc_d = acc_q;
    t_d = t_q;
    eta_d = eta_q;
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    phi_d = phi_q;
    dabs_e_d = dabs_e_q;
    dabs_p_d = dabs_p_q;
    d2_d = d2_q;
    mul_a = ax;
    mul_b = ax;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ccis_pkg::CFG_CONE_RADIUS: cone_radius_d = cfg_data_i;
        ccis_pkg::CFG_ETA_LIMIT:   eta_limit_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      ccis_pkg::ST_IDLE: begin
        if (in_acc) begin
          px_d = mom_x_i;
          py_d = mom_y_i;
          pz_d = mom_z_i;
          start_d = (req_type_i == ccis_pkg::REQ_START);
          unique case (req_type_i)
            ccis_pkg::REQ_START: state_d = ccis_pkg::ST_SQX;
            ccis_pkg::REQ_PART: begin
              if (status_i == ccis_pkg::STATUS_FINAL && charge_i != 3'sd0) begin
                state_d = ccis_pkg::ST_SQX;
              end
            end
            ccis_pkg::REQ_END: begin
              out_valid_d = 1'b1;
              cone_sum_d = sum_q;
            end
            default: ;
          endcase
        end
      end
      ccis_pkg::ST_SQX: state_d = ccis_pkg::ST_SQY;
      ccis_pkg::ST_SQY: begin
        mul_a = ay;
        mul_b = ay;
        ptsq_d = prod;
        state_d = ccis_pkg::ST_SQZ;
      end
      ccis_pkg::ST_SQZ: begin
        mul_a = az;
        mul_b = az;
        ptsq_d = ptsq_q + prod;
        state_d = ccis_pkg::ST_PTCHK;
      end
      ccis_pkg::ST_PTCHK: begin
        if (ptsq_q == 48'd0) begin
          // no transverse momentum: eta saturates, phi is zero
          if (start_q) begin
            ref_eta_d = pz_q[23] ? -ETA_SAT : ETA_SAT;
            ref_phi_d = '0;
            sum_d = '0;
          end
          state_d = ccis_pkg::ST_IDLE;
        end else begin
          work_d = {ptsq_q, 14'd0};
          ptsq_d = ptsq_q + prod;
          rem_d = '0;
          root_d = '0;
          cnt_d = '0;
          state_d = ccis_pkg::ST_SQRT_PT;
        end
      end
      ccis_pkg::ST_SQRT_PT, ccis_pkg::ST_SQRT_P: begin
        rem_d = ge ? diff : sub_a;
        root_d = root_nx;
        work_d = {work_q[59:0], 2'b00};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd30) begin
          rem_d = '0;
          root_d = '0;
          cnt_d = '0;
          if (state_q == ccis_pkg::ST_SQRT_PT) begin
            pt7_d = root_nx;
            work_d = {ptsq_q, 14'd0};
            state_d = ccis_pkg::ST_SQRT_P;
          end else begin
            pt_d = 25'((32'(pt7_q) + 32'd64) >> 7);
            work_d = {6'd0, num, 24'd0};
            state_d = ccis_pkg::ST_DIV;
          end
        end
      end
      ccis_pkg::ST_DIV: begin
        rem_d = ge ? diff : sub_a;
        work_d = {6'd0, work_q[54:0], ge};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd55) begin
          acc_d = '0;
          state_d = ccis_pkg::ST_NORM;
        end
      end
      ccis_pkg::ST_NORM: begin
        // one octave per cycle down to a mantissa in [1,2)
        if (work_q[55:25] != 31'd0) begin
          work_d = work_q >> 1;
          acc_d = acc_q + 30'(ccis_pkg::LN2_Q);
        end else begin
          t_d = 26'd1 << ccis_pkg::IQ;
          cnt_d = 6'd1;
          state_d = ccis_pkg::ST_LN;
        end
      end
      ccis_pkg::ST_LN: begin
        if (ln_c <= {1'b0, work_q[24:0]}) begin
          t_d = ln_c;
          acc_d = acc_q + 30'(ccis_pkg::ln1p_step(cnt_q));
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(S)) begin
          state_d = ccis_pkg::ST_ETA;
        end
      end
      ccis_pkg::ST_ETA: begin
        eta_d = pz_q[23] ? -mag : mag;
        state_d = ccis_pkg::ST_ROT;
      end
      ccis_pkg::ST_ROT: begin
        x_d = x0;
        y_d = y0;
        z_d = '0;
        if (px_q[23]) begin
          if (!py_q[23]) begin
            x_d = y0;
            y_d = -x0;
            z_d = 28'(ccis_pkg::HALF_PI_Q);
          end else begin
            x_d = -y0;
            y_d = x0;
            z_d = -28'(ccis_pkg::HALF_PI_Q);
          end
        end
        cnt_d = '0;
        state_d = ccis_pkg::ST_CORDIC;
      end
      ccis_pkg::ST_CORDIC: begin
        if (y_q > 36'sd0) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + atn;
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - atn;
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(S - 1)) begin
          state_d = ccis_pkg::ST_PHI;
        end
      end
      ccis_pkg::ST_PHI: begin
        phi_d = PHI_W'(zr >>> SHR);
        if (start_q) begin
          if (eta_q > ETA_SAT_W) begin
            ref_eta_d = ETA_SAT;
          end else if (eta_q < -ETA_SAT_W) begin
            ref_eta_d = -ETA_SAT;
          end else begin
            ref_eta_d = REF_ETA_W'(eta_q);
          end
          ref_phi_d = PHI_W'(zr >>> SHR);
          sum_d = '0;
          state_d = ccis_pkg::ST_IDLE;
        end else begin
          state_d = ccis_pkg::ST_CUT;
        end
      end
      ccis_pkg::ST_CUT: begin
        dabs_e_d = deta[DETA_W-1] ? DETA_W'(-deta) : DETA_W'(deta);
        dabs_p_d = dphi[DPHI_W-1] ? DPHI_W'(-dphi) : DPHI_W'(dphi);
        state_d = (cut_l >= cut_r) ? ccis_pkg::ST_IDLE : ccis_pkg::ST_SQE;
      end
      ccis_pkg::ST_SQE: begin
        mul_a = 24'(dabs_e_q);
        mul_b = 24'(dabs_e_q);
        state_d = ccis_pkg::ST_SQP;
      end
      ccis_pkg::ST_SQP: begin
        mul_a = 24'(dabs_p_q);
        mul_b = 24'(dabs_p_q);
        d2_d = D2_W'(prod);
        state_d = ccis_pkg::ST_SQR;
      end
      ccis_pkg::ST_SQR: begin
        mul_a = 24'(cone_radius_q);
        mul_b = 24'(cone_radius_q);
        d2_d = d2_q + D2_W'(prod);
        state_d = ccis_pkg::ST_DEC;
      end
      ccis_pkg::ST_DEC: begin
        // inner cone 0.01 and outer radius, compared on squares
        if (64'(d2_q) > D2_MIN && cmp_l < cmp_r) begin
          sum_d = sum_ext[32] ? 32'hFFFF_FFFF : sum_ext[31:0];
        end
        state_d = ccis_pkg::ST_IDLE;
      end
      default: state_d = ccis_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ccis_pkg::ST_IDLE;
      cone_radius_q <= 14'd410;
      eta_limit_q <= 14'd2560;
      ref_eta_q <= '0;
      ref_phi_q <= '0;
      sum_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cone_radius_q <= cone_radius_d;
      eta_limit_q <= eta_limit_d;
      ref_eta_q <= ref_eta_d;
      ref_phi_q <= ref_phi_d;
      sum_q <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cone_sum_q <= cone_sum_d;
    px_q <= px_d;
    py_q <= py_d;
    pz_q <= pz_d;
    start_q <= start_d;
    ptsq_q <= ptsq_d;
    work_q <= work_d;
    rem_q <= rem_d;
    root_q <= root_d;
    pt7_q <= pt7_d;
    pt_q <= pt_d;
    cnt_q <= cnt_d;
    acc_q <= acc_d;
    t_q <= t_d;
    eta_q <= eta_d;
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    phi_q <= phi_d;
    dabs_e_q <= dabs_e_d;
    dabs_p_q <= dabs_p_d;
    d2_q <= d2_d;
  end

endmodule
